// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check.
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication check, same-cycle consequent.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication check, next-cycle consequent.
`define CHK_IMPLY_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rnp_pkg.sv
// ----------------------------------------------------------------------------
// rnp_pkg
// Types, constants and the character-to-digit decode for the number parser.
// ----------------------------------------------------------------------------
package rnp_pkg;

    localparam int VALUE_BITS = 32;
    localparam int OUT_W      = 32;
    localparam int ADV_W      = 16;
    localparam int MODE_W     = 2;
    localparam int DIGIT_W    = 5;

    localparam logic [MODE_W-1:0] RADIX_OCT = 2'd0;
    localparam logic [MODE_W-1:0] RADIX_DEC = 2'd1;
    localparam logic [MODE_W-1:0] RADIX_HEX = 2'd2;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    localparam logic [DIGIT_W-1:0] NO_DIGIT = 5'd16;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    has_digits;
        logic [ADV_W-1:0]        advance;
    } rnp_result_t;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'(NO_DIGIT);
            if (c >= CHAR_0 && c <= CHAR_9)
                d = c - CHAR_0;
            else if (c >= CHAR_UA && c <= CHAR_UF)
                d = c - CHAR_UA + 8'd10;
            else if (c >= CHAR_LA && c <= CHAR_LF)
                d = c - CHAR_LA + 8'd10;
            return d[DIGIT_W-1:0];
        end
    endfunction

    function automatic logic [DIGIT_W-1:0] radix_of(input logic [MODE_W-1:0] mode);
        logic [DIGIT_W-1:0] r;
        begin
            case (mode)
                RADIX_OCT: r = 5'd8;
                RADIX_HEX: r = 5'd16;
                default:   r = 5'd10;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/core/rnp_in_stage.sv
// ----------------------------------------------------------------------------
// rnp_in_stage
// Input register: holds one character item until the core consumes it.
// ----------------------------------------------------------------------------
module rnp_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       end_of_text,
    input  logic       consume,
    output logic       item_valid,
    output logic [7:0] item_ch,
    output logic       item_eot
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;
    logic       eot_reg;
    logic       load;

    assign in_ready   = !valid_reg || consume;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ch_reg  <= ch;
            eot_reg <= end_of_text;
        end
    end

    assign item_valid = valid_reg;
    assign item_ch    = ch_reg;
    assign item_eot   = eot_reg;

endmodule

// File: rtl/core/rnp_core.sv
// ----------------------------------------------------------------------------
// rnp_core
// Parse state and one-step update: sign, radix multiply-add, close and result.
// ----------------------------------------------------------------------------
module rnp_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rnp_pkg::MODE_W-1:0]   radix_mode,
    input  logic                         item_valid,
    input  logic [7:0]                   item_ch,
    input  logic                         item_eot,
    input  logic                         can_load,
    output logic                         consume,
    output logic                         emit,
    output rnp_pkg::rnp_result_t         result
);

    import rnp_pkg::*;

    logic                  at_start_reg;
    logic                  at_start_next;
    logic                  negative_reg;
    logic                  negative_next;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic [ADV_W-1:0]      count_reg;
    logic [ADV_W-1:0]      count_next;
    logic                  seen_reg;
    logic                  seen_next;

    logic [DIGIT_W-1:0]    digit;
    logic                  sign_here;
    logic                  is_digit;
    logic                  closes;
    logic [VALUE_BITS-1:0] acc_scaled;
    logic [VALUE_BITS-1:0] mag;

    assign digit     = digit_of(item_ch);
    assign sign_here = at_start_reg && !item_eot
                       && (item_ch == CHAR_PLUS || item_ch == CHAR_MINUS);
    assign is_digit  = digit < radix_of(radix_mode);
    assign closes    = item_eot || (!sign_here && !is_digit);
    assign consume   = item_valid && (!closes || can_load);
    assign emit      = item_valid && closes && can_load;

    always_comb
    begin
        case (radix_mode)
            RADIX_OCT: acc_scaled = acc_reg << 3;
            RADIX_HEX: acc_scaled = acc_reg << 4;
            default:   acc_scaled = (acc_reg << 3) + (acc_reg << 1);
        endcase
    end

    always_comb
    begin
        at_start_next = at_start_reg;
        negative_next = negative_reg;
        acc_next      = acc_reg;
        count_next    = count_reg;
        seen_next     = seen_reg;
        if (consume)
        begin
            if (closes)
            begin
                at_start_next = 1'b1;
                negative_next = 1'b0;
                acc_next      = '0;
                count_next    = '0;
                seen_next     = 1'b0;
            end
            else if (sign_here)
            begin
                at_start_next = 1'b0;
                negative_next = (item_ch == CHAR_MINUS);
                count_next    = ADV_W'(1);
            end
            else
            begin
                at_start_next = 1'b0;
                acc_next      = acc_scaled + VALUE_BITS'(digit);
                seen_next     = 1'b1;
                if (count_reg != '1)
                    count_next = count_reg + ADV_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            negative_reg <= 1'b0;
            acc_reg      <= '0;
            count_reg    <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            at_start_reg <= at_start_next;
            negative_reg <= negative_next;
            acc_reg      <= acc_next;
            count_reg    <= count_next;
            seen_reg     <= seen_next;
        end
    end

    assign mag = negative_reg ? (VALUE_BITS'(0) - acc_reg) : acc_reg;

    always_comb
    begin
        result.value      = seen_reg ? OUT_W'(signed'(mag)) : '0;
        result.has_digits = seen_reg;
        result.advance    = seen_reg ? count_reg : '0;
    end

endmodule

// File: rtl/core/rnp_out_stage.sv
// ----------------------------------------------------------------------------
// rnp_out_stage
// Result register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module rnp_out_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           emit,
    input  rnp_pkg::rnp_result_t           result,
    output logic                           can_load,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [rnp_pkg::OUT_W-1:0] value,
    output logic                           has_digits,
    output logic [rnp_pkg::ADV_W-1:0]      advance
);

    import rnp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    rnp_result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign value      = result_reg.value;
    assign has_digits = result_reg.has_digits;
    assign advance    = result_reg.advance;

endmodule

// File: rtl/core/signed_radix_number_parser.sv
// ----------------------------------------------------------------------------
// signed_radix_number_parser
// Streams text one character per item and returns one parsed signed number
// per sign/digit run, in octal, decimal or hexadecimal.
// ----------------------------------------------------------------------------
// Channels: the input channel (in_valid/in_ready) carries ch and end_of_text;
// the output channel (out_valid/out_ready) carries value, has_digits and
// advance. The cfg channel (cfg_valid/cfg_ready) writes radix_mode; write it
// only while no item is in flight. cfg_ready is always high.
// Throughput: one character per cycle. The accepted item sits in an input
// register; from there the multiply-add and close decision run, and a
// closing item loads the result register once that register can take it.
// Stall: while out_ready is low and a result is held, characters that do not
// close a number keep flowing; a closing one waits in the input register and
// in_ready drops until the result is taken.
// Reset: radix_mode returns to decimal, the parse state clears and both
// registers empty.
// ----------------------------------------------------------------------------
module signed_radix_number_parser
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rnp_pkg::MODE_W-1:0]       radix_mode,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       ch,
    input  logic                             end_of_text,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [rnp_pkg::OUT_W-1:0] value,
    output logic                             has_digits,
    output logic [rnp_pkg::ADV_W-1:0]        advance
);

    import rnp_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic              consume;
    logic              emit;
    logic              can_load;
    logic              item_valid;
    logic [7:0]        item_ch;
    logic              item_eot;
    rnp_result_t       result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= RADIX_DEC;
        end
        else if (cfg_valid)
        begin
            mode_reg <= radix_mode;
        end
    end

    rnp_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .end_of_text (end_of_text),
        .consume     (consume),
        .item_valid  (item_valid),
        .item_ch     (item_ch),
        .item_eot    (item_eot)
    );

    rnp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .radix_mode (mode_reg),
        .item_valid (item_valid),
        .item_ch    (item_ch),
        .item_eot   (item_eot),
        .can_load   (can_load),
        .consume    (consume),
        .emit       (emit),
        .result     (result)
    );

    rnp_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .result     (result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .has_digits (has_digits),
        .advance    (advance)
    );

endmodule

// File: rtl/core/rnp_checker.sv
// ----------------------------------------------------------------------------
// rnp_checker
// Port-level checks on the number parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rnp_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_ready,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [rnp_pkg::OUT_W-1:0] value,
    input logic                             has_digits,
    input logic [rnp_pkg::ADV_W-1:0]        advance
);

    // empty number: nothing consumed, value zero
    `CHK_IMPLY(a_empty_zero, out_valid && !has_digits,
        value == '0 && advance == '0, "empty number with nonzero value or advance")

    // a number with digits consumed at least one character
    `CHK_IMPLY(a_digits_advance, out_valid && has_digits, advance != '0,
        "digits seen but advance is zero")

    // held result stays put while stalled
    `CHK_IMPLY_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable({value, has_digits, advance}), "result changed while stalled")

    // input only stalls behind a held result
    `CHK_IMPLY(a_in_stall, !in_ready, out_valid && !out_ready,
        "in_ready low without a stalled result")

    // config port never back-pressures
    `CHK_ASSERT(a_cfg_ready, cfg_ready, "cfg_ready dropped")

endmodule

bind signed_radix_number_parser rnp_checker u_rnp_checker (.*);
